// File: rtl/b64u_pkg.sv
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types and codes for the base64 decoder with UTF-8 checking.
// ----------------------------------------------------------------------------
package b64u_pkg;

  // character classes passed from the front end to the back end
  localparam logic [1:0] CLS_SKIP = 2'd0;
  localparam logic [1:0] CLS_PAD  = 2'd1;
  localparam logic [1:0] CLS_SYM  = 2'd2;
  localparam logic [1:0] CLS_BAD  = 2'd3;

  // final status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_BAD_CHAR  = 4'd1;
  localparam logic [3:0] ST_AFTER_PAD = 4'd2;
  localparam logic [3:0] ST_TOO_LONG  = 4'd3;
  localparam logic [3:0] ST_EMPTY     = 4'd4;
  localparam logic [3:0] ST_DANGLING  = 4'd5;
  localparam logic [3:0] ST_PADS      = 4'd6;
  localparam logic [3:0] ST_BITS      = 4'd7;
  localparam logic [3:0] ST_UTF8      = 4'd8;

  // byte limit after reset
  localparam logic [23:0] MAX_BYTES_RESET = 24'd65536;

  // classified character, one queue entry
  typedef struct packed {
    logic [1:0] cls;
    logic [5:0] sym;
    logic       eos;
  } cmd_t;

  // one result: a decoded byte or a final status
  typedef struct packed {
    logic       is_status;
    logic [7:0] value;
    logic       last;
  } res_t;

endpackage

// File: rtl/b64u_front.sv
// ----------------------------------------------------------------------------
// b64u_front
// Accepts characters, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module b64u_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       char_code,
  input  logic             char_present,
  input  logic             end_of_string,
  output logic             cmd_valid,
  output b64u_pkg::cmd_t   cmd,
  input  logic             cmd_take
);

  b64u_pkg::cmd_t slots [2];
  logic           rd_ptr;
  logic           wr_ptr;
  logic [1:0]     count;
  logic [1:0]     count_next;

  b64u_pkg::cmd_t entry;
  logic           accept;
  logic           keep;
  logic           blank;

  // classify the incoming character
  always_comb begin
    blank = (char_code == 8'h20) || (char_code == 8'h09) || (char_code == 8'h0a) ||
            (char_code == 8'h0d) || (char_code == 8'h0b) || (char_code == 8'h0c);
    entry.eos = end_of_string;
    entry.sym = 6'd0;
    entry.cls = b64u_pkg::CLS_BAD;
    if (!char_present || blank) begin
      entry.cls = b64u_pkg::CLS_SKIP;
    end else if (char_code == 8'h3d) begin
      entry.cls = b64u_pkg::CLS_PAD;
    end else if (char_code >= 8'h41 && char_code <= 8'h5a) begin
      entry.cls = b64u_pkg::CLS_SYM;
      entry.sym = 6'(char_code - 8'h41);
    end else if (char_code >= 8'h61 && char_code <= 8'h7a) begin
      entry.cls = b64u_pkg::CLS_SYM;
      entry.sym = 6'(char_code - 8'h61 + 8'd26);
    end else if (char_code >= 8'h30 && char_code <= 8'h39) begin
      entry.cls = b64u_pkg::CLS_SYM;
      entry.sym = 6'(char_code - 8'h30 + 8'd52);
    end else if (char_code == 8'h2b) begin
      entry.cls = b64u_pkg::CLS_SYM;
      entry.sym = 6'd62;
    end else if (char_code == 8'h2f) begin
      entry.cls = b64u_pkg::CLS_SYM;
      entry.sym = 6'd63;
    end
  end

  // items that carry no character or only a blank, and do not end the string, are dropped here
  assign full   = (count == 2'd2);
  assign accept = push && !full;
  assign keep   = accept && ((entry.cls != b64u_pkg::CLS_SKIP) || entry.eos);

  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (keep && !cmd_take) begin
      count_next = count + 2'd1;
    end else if (!keep && cmd_take) begin
      count_next = count - 2'd1;
    end
  end

  // queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (keep) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (keep) begin
      slots[wr_ptr] <= entry;
    end
  end

endmodule

// File: rtl/b64u_back.sv
// ----------------------------------------------------------------------------
// b64u_back
// Decode state, byte limit, UTF-8 check and final status; result queue.
// ----------------------------------------------------------------------------
module b64u_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic [23:0]      max_output_bytes,
  input  logic             cmd_valid,
  input  b64u_pkg::cmd_t   cmd,
  output logic             cmd_take,
  output logic             empty,
  input  logic             pop,
  output b64u_pkg::res_t   res
);

  // decode state
  logic [23:0] max_bytes;
  logic [11:0] acc,       acc_next;
  logic [2:0]  bit_cnt,   bit_cnt_next;
  logic [1:0]  pad_cnt,   pad_cnt_next;
  logic [1:0]  phase,     phase_next;
  logic        seen,      seen_next;
  logic [24:0] out_cnt,   out_cnt_next;
  logic [3:0]  first_err, first_err_next;
  logic [1:0]  u_rem,     u_rem_next;
  logic [2:0]  u_len,     u_len_next;
  logic [20:0] u_cp,      u_cp_next;
  logic        u_bad,     u_bad_next;

  logic [3:0]  bc_sum;
  logic [24:0] cnt_inc;
  logic        emit;
  logic [7:0]  byte_out;
  logic [20:0] cp_shift;
  logic        left_bits;
  logic [3:0]  final_st;

  // result queue
  b64u_pkg::res_t slots [4];
  logic [1:0]     rd_ptr;
  logic [1:0]     wr_ptr;
  logic [2:0]     count;
  logic           pop_ok;
  logic           do_emit;
  logic           do_end;
  logic [1:0]     n_push;
  b64u_pkg::res_t res_a;
  b64u_pkg::res_t res_b;

  assign cmd_take = cmd_valid && (count < 3'd3);

  // character step: padding, errors, bit accumulation, byte limit
  always_comb begin
    acc_next       = acc;
    bit_cnt_next   = bit_cnt;
    pad_cnt_next   = pad_cnt;
    phase_next     = phase;
    seen_next      = seen;
    out_cnt_next   = out_cnt;
    first_err_next = first_err;
    emit           = 1'b0;
    byte_out       = 8'd0;
    bc_sum         = {1'b0, bit_cnt} + 4'd6;
    cnt_inc        = out_cnt + 25'd1;
    if (cmd.cls != b64u_pkg::CLS_SKIP && first_err == b64u_pkg::ST_OK) begin
      if (cmd.cls == b64u_pkg::CLS_PAD) begin
        if (pad_cnt != 2'd3) begin
          pad_cnt_next = pad_cnt + 2'd1;
        end
      end else if (pad_cnt != 2'd0) begin
        first_err_next = b64u_pkg::ST_AFTER_PAD;
      end else if (cmd.cls == b64u_pkg::CLS_BAD) begin
        first_err_next = b64u_pkg::ST_BAD_CHAR;
      end else begin
        acc_next   = {acc[5:0], cmd.sym};
        phase_next = phase + 2'd1;
        seen_next  = 1'b1;
        if (bc_sum >= 4'd8) begin
          bit_cnt_next = 3'(bc_sum - 4'd8);
          out_cnt_next = cnt_inc;
          if (cnt_inc > {1'b0, max_bytes}) begin
            first_err_next = b64u_pkg::ST_TOO_LONG;
          end else begin
            emit     = 1'b1;
            byte_out = 8'(acc_next >> bit_cnt_next);
          end
        end else begin
          bit_cnt_next = bc_sum[2:0];
        end
      end
    end
  end

  // utf-8 check on each emitted byte
  always_comb begin
    u_rem_next = u_rem;
    u_len_next = u_len;
    u_cp_next  = u_cp;
    u_bad_next = u_bad;
    cp_shift   = {u_cp[14:0], byte_out[5:0]};
    if (emit && !u_bad) begin
      if (u_rem == 2'd0) begin
        if (byte_out[7]) begin
          if (byte_out[7:5] == 3'b110) begin
            u_len_next = 3'd2;
            u_cp_next  = {16'd0, byte_out[4:0]};
            u_rem_next = 2'd1;
          end else if (byte_out[7:4] == 4'b1110) begin
            u_len_next = 3'd3;
            u_cp_next  = {17'd0, byte_out[3:0]};
            u_rem_next = 2'd2;
          end else if (byte_out[7:3] == 5'b11110) begin
            u_len_next = 3'd4;
            u_cp_next  = {18'd0, byte_out[2:0]};
            u_rem_next = 2'd3;
          end else begin
            u_bad_next = 1'b1;
          end
        end
      end else if (byte_out[7:6] != 2'b10) begin
        u_bad_next = 1'b1;
        u_rem_next = 2'd0;
      end else begin
        u_cp_next  = cp_shift;
        u_rem_next = u_rem - 2'd1;
        if (u_rem == 2'd1) begin
          if ((u_len == 3'd2 && cp_shift < 21'h80) ||
              (u_len == 3'd3 && cp_shift < 21'h800) ||
              (u_len == 3'd4 && cp_shift < 21'h10000) ||
              (cp_shift > 21'h10FFFF) ||
              (cp_shift >= 21'hD800 && cp_shift <= 21'hDFFF)) begin
            u_bad_next = 1'b1;
          end
        end
      end
    end
  end

  // end-of-string verdict, first error wins
  always_comb begin
    case (bit_cnt_next)
      3'd0:    left_bits = 1'b0;
      3'd2:    left_bits = |acc_next[1:0];
      3'd4:    left_bits = |acc_next[3:0];
      default: left_bits = |acc_next[5:0];
    endcase
    if (first_err_next != b64u_pkg::ST_OK) begin
      final_st = first_err_next;
    end else if (!seen_next) begin
      final_st = b64u_pkg::ST_EMPTY;
    end else if (phase_next == 2'd1) begin
      final_st = b64u_pkg::ST_DANGLING;
    end else if (pad_cnt_next == 2'd3) begin
      final_st = b64u_pkg::ST_PADS;
    end else if (left_bits) begin
      final_st = b64u_pkg::ST_BITS;
    end else if (u_bad_next || u_rem_next != 2'd0) begin
      final_st = b64u_pkg::ST_UTF8;
    end else begin
      final_st = b64u_pkg::ST_OK;
    end
  end

  // register and decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= b64u_pkg::MAX_BYTES_RESET;
      acc       <= 12'd0;
      bit_cnt   <= 3'd0;
      pad_cnt   <= 2'd0;
      phase     <= 2'd0;
      seen      <= 1'b0;
      out_cnt   <= 25'd0;
      first_err <= b64u_pkg::ST_OK;
      u_rem     <= 2'd0;
      u_len     <= 3'd0;
      u_cp      <= 21'd0;
      u_bad     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        max_bytes <= max_output_bytes;
      end
      if (cmd_take && cmd.eos) begin
        acc       <= 12'd0;
        bit_cnt   <= 3'd0;
        pad_cnt   <= 2'd0;
        phase     <= 2'd0;
        seen      <= 1'b0;
        out_cnt   <= 25'd0;
        first_err <= b64u_pkg::ST_OK;
        u_rem     <= 2'd0;
        u_len     <= 3'd0;
        u_cp      <= 21'd0;
        u_bad     <= 1'b0;
      end else if (cmd_take) begin
        acc       <= acc_next;
        bit_cnt   <= bit_cnt_next;
        pad_cnt   <= pad_cnt_next;
        phase     <= phase_next;
        seen      <= seen_next;
        out_cnt   <= out_cnt_next;
        first_err <= first_err_next;
        u_rem     <= u_rem_next;
        u_len     <= u_len_next;
        u_cp      <= u_cp_next;
        u_bad     <= u_bad_next;
      end
    end
  end

  // results of this step, byte first then status
  always_comb begin
    do_emit = cmd_take && emit;
    do_end  = cmd_take && cmd.eos;
    n_push  = {1'b0, do_emit} + {1'b0, do_end};
    res_b.is_status = 1'b1;
    res_b.value     = {4'd0, final_st};
    res_b.last      = 1'b1;
    if (do_emit) begin
      res_a.is_status = 1'b0;
      res_a.value     = byte_out;
      res_a.last      = !cmd.eos;
    end else begin
      res_a = res_b;
    end
  end

  assign empty  = (count == 3'd0);
  assign pop_ok = pop && !empty;
  assign res    = slots[rd_ptr];

  // result queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 2'd0;
      wr_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, n_push} - {2'd0, pop_ok};
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      slots[wr_ptr] <= res_a;
    end
    if (n_push == 2'd2) begin
      slots[wr_ptr + 2'd1] <= res_b;
    end
  end

endmodule

// File: rtl/base64_decoder_utf8_check.sv
// ----------------------------------------------------------------------------
// base64_decoder_utf8_check
// Streaming base64 decoder with byte limit and UTF-8 validation.
// ----------------------------------------------------------------------------
// Input channel: one character per transfer (push while full is low), with
// char_present and end_of_string. Output channel: a queue of results (pop
// while empty is low); each is a decoded byte (byte_valid) or, for the item
// that ends a string, the final status (status_valid). run_last marks the
// last result of an input item; an item gives zero, one or two results.
// max_output_bytes is written with cfg_write_en; the user must write it only
// while the block is idle, which the block itself does not enforce. The first
// result of an item passes the character queue and then the result queue.
// Throughput: one item per cycle, set by the decode step in the back end
// while the result queue holds under three results; an item with two
// results needs two pops. A stalled receiver fills the four-entry result
// queue to three results or more; the back end then stops taking from the
// two-entry character queue and full rises. Reset empties both queues,
// clears the string state and sets the byte limit to 65536.
// ----------------------------------------------------------------------------
module base64_decoder_utf8_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [23:0] max_output_bytes,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code,
  input  logic        char_present,
  input  logic        end_of_string,
  output logic        empty,
  input  logic        pop,
  output logic        byte_valid,
  output logic [7:0]  data_byte,
  output logic        status_valid,
  output logic [3:0]  status,
  output logic        run_last
);

  logic           cmd_valid;
  logic           cmd_take;
  b64u_pkg::cmd_t cmd;
  b64u_pkg::res_t res;

  // classify and queue characters
  b64u_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .char_code     (char_code),
    .char_present  (char_present),
    .end_of_string (end_of_string),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take)
  );

  // decode, check and queue results
  b64u_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .max_output_bytes (max_output_bytes),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_take         (cmd_take),
    .empty            (empty),
    .pop              (pop),
    .res              (res)
  );

  // unpack the result at the head of the queue
  assign byte_valid   = !res.is_status;
  assign status_valid = res.is_status;
  assign data_byte    = res.is_status ? 8'd0 : res.value;
  assign status       = res.is_status ? res.value[3:0] : b64u_pkg::ST_OK;
  assign run_last     = res.last;

endmodule

// File: rtl/b64u_checker.sv
// ----------------------------------------------------------------------------
// b64u_checker
// Port-level checks for the base64 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64u_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_write_en,
  input logic [23:0] max_output_bytes,
  input logic        push,
  input logic        full,
  input logic [7:0]  char_code,
  input logic        char_present,
  input logic        end_of_string,
  input logic        empty,
  input logic        pop,
  input logic        byte_valid,
  input logic [7:0]  data_byte,
  input logic        status_valid,
  input logic [3:0]  status,
  input logic        run_last
);

  // reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // a result is exactly one kind
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (byte_valid != status_valid))
    else $error("result is neither or both byte and status");

  // a status result is always the last of its item and carries no byte
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && status_valid) |-> (run_last && data_byte == 8'd0 &&
                                  status <= b64u_pkg::ST_UTF8))
    else $error("bad status result");

  // a byte result carries no status code
  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && byte_valid) |-> (status == b64u_pkg::ST_OK))
    else $error("byte result with status code");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(data_byte) && $stable(status) &&
                          $stable(byte_valid) && $stable(run_last)))
    else $error("stalled result changed");

endmodule

bind base64_decoder_utf8_check b64u_checker u_b64u_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming base64 decoder with UTF-8 check.
// A directed table covers the end checks and error codes. Random strings
// follow, most of them well-formed encodings of UTF-8-heavy byte streams
// and the rest noise or damaged. The byte limit changes between phases.
// Every result transfer is compared with the in-bench decoder's output.
// ----------------------------------------------------------------------------
module tb_top;
  import b64u_pkg::*;

  localparam int N_RANDOM  = 1500;
  localparam int WD_LIMIT  = 2000;
  localparam int SETTLE    = 8;
  localparam int TAIL      = 10;
  localparam int PHASE_LEN = 150;

  localparam logic [7:0] CH_PAD = 8'h3D;

  typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [23:0] lim_val;
    logic [7:0]  c;
    logic        p;
    logic        e;
    logic        typed;
    logic [3:0]  st;
  } step_row_t;

  typedef struct packed {
    logic       bv;
    logic [7:0] db;
    logic       sv;
    logic [3:0] st;
    logic       last;
  } result_t;

  // dut ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [23:0] max_output_bytes = MAX_BYTES_RESET;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_code = 8'h00;
  logic        char_present = 1'b0;
  logic        end_of_string = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        byte_valid;
  logic [7:0]  data_byte;
  logic        status_valid;
  logic [3:0]  status;
  logic        run_last;

  base64_decoder_utf8_check u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .max_output_bytes (max_output_bytes),
    .push             (push),
    .full             (full),
    .char_code        (char_code),
    .char_present     (char_present),
    .end_of_string    (end_of_string),
    .empty            (empty),
    .pop              (pop),
    .byte_valid       (byte_valid),
    .data_byte        (data_byte),
    .status_valid     (status_valid),
    .status           (status),
    .run_last         (run_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // decoder state mirrored in the bench
  logic [23:0] byte_limit;
  logic [11:0] acc;
  logic [3:0]  nbits;
  logic [1:0]  pads;
  logic [1:0]  phase;
  logic        seen;
  logic [24:0] nout;
  logic [3:0]  err;
  logic [1:0]  u_rem;
  logic [2:0]  u_len;
  logic [20:0] u_cp;
  logic        u_bad;

  result_t decode_q[$];
  int      n_fail = 0;
  int      n_items = 0;
  int      quiet = 0;
  int      burst_left = 0;
  int      pop_left = 0;
  int      pop_mode = 0;

  // boundary code points and the lengths they are encoded with
  logic [20:0] edge_cp [12] = '{21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD7FF, 21'hD800,
                                21'hDFFF, 21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF,
                                21'h110000};
  int          edge_len [12] = '{2, 2, 3, 3, 3, 3, 3, 3, 4, 4, 4, 4};

  // directed strings, statuses typed where they are plain to see
  step_row_t dir_rows [30] = '{
    '{ROW_CHAR, 24'd0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'hA5, 1'b0, 1'b1, 1'b1, ST_EMPTY},
    '{ROW_CHAR, 24'd0, 8'h54, 1'b1, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h57, 1'b1, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h46, 1'b1, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h75, 1'b1, 1'b1, 1'b1, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h0C, 1'b1, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h51, 1'b1, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h51, 1'b1, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h3D, 1'b1, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h3D, 1'b1, 1'b1, 1'b1, ST_OK},
    '{ROW_CHAR, 24'd0, 8'hFF, 1'b1, 1'b1, 1'b1, ST_BAD_CHAR},
    '{ROW_CHAR, 24'd0, 8'h51, 1'b1, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h3D, 1'b1, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h51, 1'b1, 1'b1, 1'b1, ST_AFTER_PAD},
    '{ROW_CHAR, 24'd0, 8'h51, 1'b1, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h0B, 1'b1, 1'b1, 1'b1, ST_DANGLING},
    '{ROW_CHAR, 24'd0, 8'h51, 1'b1, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h51, 1'b1, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h3D, 1'b1, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h3D, 1'b1, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h3D, 1'b1, 1'b1, 1'b1, ST_PADS},
    '{ROW_CHAR, 24'd0, 8'h51, 1'b1, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h52, 1'b1, 1'b1, 1'b1, ST_BITS},
    '{ROW_CHAR, 24'd0, 8'h2F, 1'b1, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h77, 1'b1, 1'b1, 1'b1, ST_UTF8},
    '{ROW_CFG,  24'd0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h51, 1'b1, 1'b0, 1'b0, ST_OK},
    '{ROW_CHAR, 24'd0, 8'h51, 1'b1, 1'b1, 1'b1, ST_TOO_LONG},
    '{ROW_CFG,  MAX_BYTES_RESET, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK}
  };

  // ---------------------------------------------------------------- decoder

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D ||
           c == 8'h0B || c == 8'h0C;
  endfunction

  function automatic int sym_of(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return int'(c - 8'h41);
    if (c >= 8'h61 && c <= 8'h7A) return int'(c - 8'h61) + 26;
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30) + 52;
    if (c == 8'h2B) return 62;
    if (c == 8'h2F) return 63;
    return -1;
  endfunction

  task automatic clear_string();
    acc = '0; nbits = '0; pads = '0; phase = '0; seen = 1'b0; nout = '0;
    err = ST_OK; u_rem = '0; u_len = '0; u_cp = '0; u_bad = 1'b0;
  endtask

  // incremental utf-8 check of each emitted byte
  task automatic utf8_track(input logic [7:0] b);
    if (u_bad) return;
    if (u_rem == 2'd0) begin
      if (b < 8'h80) return;
      if ((b & 8'hE0) == 8'hC0) begin
        u_len = 3'd2; u_cp = {16'd0, b[4:0]};
      end else if ((b & 8'hF0) == 8'hE0) begin
        u_len = 3'd3; u_cp = {17'd0, b[3:0]};
      end else if ((b & 8'hF8) == 8'hF0) begin
        u_len = 3'd4; u_cp = {18'd0, b[2:0]};
      end else begin
        u_bad = 1'b1;
        return;
      end
      u_rem = 2'(u_len - 3'd1);
      return;
    end
    if (b[7:6] != 2'b10) begin
      u_bad = 1'b1;
      u_rem = 2'd0;
      return;
    end
    u_cp = {u_cp[14:0], b[5:0]};
    u_rem = u_rem - 2'd1;
    if (u_rem == 2'd0) begin
      // overlong, out of range and surrogate code points
      if (u_len == 3'd2 && u_cp < 21'h80) u_bad = 1'b1;
      if (u_len == 3'd3 && u_cp < 21'h800) u_bad = 1'b1;
      if (u_len == 3'd4 && u_cp < 21'h10000) u_bad = 1'b1;
      if (u_cp > 21'h10FFFF) u_bad = 1'b1;
      if (u_cp >= 21'hD800 && u_cp <= 21'hDFFF) u_bad = 1'b1;
    end
  endtask

  task automatic decode_char(input logic [7:0] c, output logic got, output logic [7:0] b);
    int v;
    got = 1'b0;
    b = 8'h00;
    if (err != ST_OK || is_blank(c)) return;
    if (c == CH_PAD) begin
      if (pads != 2'd3) pads = pads + 2'd1;
      return;
    end
    if (pads != 2'd0) begin
      err = ST_AFTER_PAD;
      return;
    end
    v = sym_of(c);
    if (v < 0) begin
      err = ST_BAD_CHAR;
      return;
    end
    acc = {acc[5:0], 6'(v)};
    nbits = nbits + 4'd6;
    phase = phase + 2'd1;
    seen = 1'b1;
    if (nbits >= 4'd8) begin
      nbits = nbits - 4'd8;
      nout = nout + 25'd1;
      // the byte that crosses the limit is dropped
      if (nout > {1'b0, byte_limit}) begin
        err = ST_TOO_LONG;
        return;
      end
      b = 8'(acc >> nbits);
      got = 1'b1;
      utf8_track(b);
    end
  endtask

  function automatic logic [3:0] string_verdict();
    logic [11:0] mask;
    mask = (12'd1 << nbits) - 12'd1;
    if (err != ST_OK) return err;
    if (!seen) return ST_EMPTY;
    if (phase == 2'd1) return ST_DANGLING;
    if (pads > 2'd2) return ST_PADS;
    if (nbits != 4'd0 && (acc & mask) != 12'd0) return ST_BITS;
    if (u_bad || u_rem != 2'd0) return ST_UTF8;
    return ST_OK;
  endfunction

  // expected results of one accepted item
  task automatic decode_item(input logic [7:0] c, input logic p, input logic e);
    logic       got;
    logic [7:0] b;
    got = 1'b0;
    b = 8'h00;
    if (p) decode_char(c, got, b);
    if (got) decode_q.push_back('{1'b1, b, 1'b0, ST_OK, ~e});
    if (e) begin
      decode_q.push_back('{1'b0, 8'h00, 1'b1, string_verdict(), 1'b1});
      clear_string();
    end
  endtask

  // ---------------------------------------------------------------- sender

  // one input transfer, with bursts and gaps between them
  task automatic send_item(input logic [7:0] c, input logic p, input logic e);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    push          <= 1'b1;
    char_code     <= c;
    char_present  <= p;
    end_of_string <= e;
    do @(posedge clk); while (full);
    decode_item(c, p, e);
    if (p || e) n_items++;
  endtask

  // hold the sender until every expected result has been popped
  task automatic drain(input bit settle);
    push <= 1'b0;
    do @(posedge clk); while (decode_q.size() != 0);
    if (settle) repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [23:0] v);
    drain(1'b1);
    cfg_write_en     <= 1'b1;
    max_output_bytes <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    byte_limit = v;
  endtask

  task automatic put_cp(ref logic [7:0] q[$], input logic [20:0] cp, input int len);
    case (len)
      1: q.push_back({1'b0, cp[6:0]});
      2: begin
        q.push_back({3'b110, cp[10:6]});
        q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        q.push_back({4'b1110, cp[15:12]});
        q.push_back({2'b10, cp[11:6]});
        q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        q.push_back({5'b11110, cp[20:18]});
        q.push_back({2'b10, cp[17:12]});
        q.push_back({2'b10, cp[11:6]});
        q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // one utf-8 unit, good or bad
  task automatic add_utf8(ref logic [7:0] q[$]);
    int k;
    int r;
    k = $urandom_range(0, 99);
    r = $urandom_range(2, 4);
    if (k < 30) put_cp(q, 21'($urandom_range(0, 'h7F)), 1);
    else if (k < 45) put_cp(q, 21'($urandom_range('h80, 'h7FF)), 2);
    else if (k < 58) put_cp(q, 21'($urandom_range('h800, 'hFFFF)), 3);
    else if (k < 68) put_cp(q, 21'($urandom_range('h10000, 'h10FFFF)), 4);
    else if (k < 73) begin
      // overlong form
      put_cp(q, 21'($urandom_range(0, (r == 2) ? 'h7F : (r == 3) ? 'h7FF : 'hFFFF)), r);
    end else if (k < 77) put_cp(q, 21'($urandom_range('hD800, 'hDFFF)), 3);
    else if (k < 81) put_cp(q, 21'($urandom_range('h110000, 'h1FFFFF)), 4);
    else if (k < 85) begin
      // truncated sequence
      put_cp(q, 21'($urandom_range('h80, 'h10FFFF)), r);
      q.delete(q.size() - 1);
    end else if (k < 92) begin
      r = $urandom_range(0, 11);
      put_cp(q, edge_cp[r], edge_len[r]);
    end else q.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
    if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
    return (v == 6'd62) ? 8'h2B : 8'h2F;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0A;
      3: return 8'h0D;
      4: return 8'h0B;
      default: return 8'h0C;
    endcase
  endfunction

  // one random string: mostly a clean encoding, sometimes damaged or noise
  task automatic send_string();
    logic [7:0]  bytes[$];
    logic [7:0]  chars[$];
    logic [23:0] w;
    int          target;
    int          i;
    int          rem;
    int          kind;
    bit          sep_end;
    bit          pad_on;
    kind = $urandom_range(0, 99);
    sep_end = ($urandom_range(0, 3) == 0);
    pad_on = ($urandom_range(0, 3) != 0);
    if (kind < 10) begin
      // raw noise over the whole code range
      repeat ($urandom_range(1, 12)) chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
      while (bytes.size() < target) add_utf8(bytes);
      for (i = 0; i < bytes.size(); i += 3) begin
        rem = bytes.size() - i;
        w = {bytes[i], (rem > 1) ? bytes[i+1] : 8'h00, (rem > 2) ? bytes[i+2] : 8'h00};
        chars.push_back(b64_char(w[23:18]));
        chars.push_back(b64_char(w[17:12]));
        if (rem > 1) chars.push_back(b64_char(w[11:6]));
        if (rem > 2) chars.push_back(b64_char(w[5:0]));
        if (pad_on && rem == 1) begin
          chars.push_back(CH_PAD);
          chars.push_back(CH_PAD);
        end
        if (pad_on && rem == 2) chars.push_back(CH_PAD);
      end
      // damage about a quarter of the encodings
      if (kind >= 75) begin
        case ($urandom_range(0, 4))
          0: if (chars.size() != 0)
               chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
          1: begin
            chars.push_back(CH_PAD);
            chars.push_back(b64_char(6'($urandom_range(0, 63))));
          end
          2: chars.push_back(b64_char(6'($urandom_range(0, 63))));
          3: repeat (3) chars.push_back(CH_PAD);
          default: if (chars.size() != 0) chars.delete(chars.size() - 1);
        endcase
      end
    end
    if (chars.size() == 0) sep_end = 1'b1;
    foreach (chars[k]) begin
      if ($urandom_range(0, 11) == 0) send_item(blank_char(), 1'b1, 1'b0);
      if ($urandom_range(0, 29) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(chars[k], 1'b1, (k == chars.size() - 1) && !sep_end);
    end
    // separate end mark: empty, blank or pad
    if (sep_end) begin
      case ($urandom_range(0, 2))
        0: send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        1: send_item(blank_char(), 1'b1, 1'b1);
        default: send_item(CH_PAD, 1'b1, 1'b1);
      endcase
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    result_t     last_res;
    logic [23:0] lim;
    int          ph;
    int          phase_end;
    int          hold_at;
    bit          held;
    byte_limit = MAX_BYTES_RESET;
    clear_string();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        write_limit(dir_rows[k].lim_val);
      end else begin
        send_item(dir_rows[k].c, dir_rows[k].p, dir_rows[k].e);
        if (dir_rows[k].typed) begin
          last_res = decode_q[decode_q.size() - 1];
          last_res.st = dir_rows[k].st;
          decode_q[decode_q.size() - 1] = last_res;
        end
      end
    end

    // random phases, each with its own byte limit
    n_items = 0;
    ph = 0;
    while (n_items < N_RANDOM) begin
      case (ph % 8)
        0: lim = 24'hFFFFFF;
        1: lim = 24'd1;
        2: lim = 24'd0;
        3: lim = 24'($urandom_range(2, 8));
        4: lim = MAX_BYTES_RESET;
        5: lim = 24'($urandom_range(9, 40));
        6: lim = 24'($urandom_range(0, 'hFFFFFF));
        default: lim = 24'($urandom_range(3, 20));
      endcase
      write_limit(lim);
      phase_end = n_items + PHASE_LEN;
      hold_at = n_items + $urandom_range(20, PHASE_LEN - 20);
      held = 1'b0;
      while (n_items < phase_end) begin
        if (!held && n_items >= hold_at) begin
          drain(1'b0);
          held = 1'b1;
        end
        send_string();
      end
      ph++;
    end

    drain(1'b1);
    repeat (TAIL) @(posedge clk);
    if (n_fail == 0 && decode_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  task automatic report(input string name, input logic [7:0] want_v, input logic [7:0] got_v);
    n_fail++;
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
  endtask

  // result check, watchdog count and pop pattern
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst) begin
      pop <= 1'b0;
      quiet <= 0;
    end else begin
      if (pop && !empty) begin
        if (decode_q.size() == 0) begin
          n_fail++;
          $display("%0t: result with none expected, actual bv=%0d db=%0h sv=%0d st=%0d last=%0d",
                   $time, byte_valid, data_byte, status_valid, status, run_last);
        end else begin
          want = decode_q.pop_front();
          if (byte_valid !== want.bv) report("byte_valid", 8'(want.bv), 8'(byte_valid));
          if (data_byte !== want.db) report("data_byte", want.db, data_byte);
          if (status_valid !== want.sv) report("status_valid", 8'(want.sv), 8'(status_valid));
          if (status !== want.st) report("status", 8'(want.st), 8'(status));
          if (run_last !== want.last) report("run_last", 8'(want.last), 8'(run_last));
        end
      end
      // cycles with no transfer on either side
      if ((pop && !empty) || (push && !full)) quiet <= 0;
      else quiet <= quiet + 1;
      if (pop_left == 0) begin
        pop_mode <= $urandom_range(0, 3);
        pop_left <= $urandom_range(1, 40);
      end else begin
        pop_left <= pop_left - 1;
      end
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 3) != 0);
        default: pop <= 1'b0;
      endcase
    end
  end

  initial begin : watchdog
    while (quiet < WD_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
rtl/b64u_pkg.sv
rtl/b64u_front.sv
rtl/b64u_back.sv
rtl/base64_decoder_utf8_check.sv
rtl/b64u_checker.sv
tb/tb_top.sv
